// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers shared by the scaler rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every rising clock edge outside reset
`define ADSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen outside reset
`define ADSS_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ADSS_ASSERT(label, clk, rst, prop, msg)
`define ADSS_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// File: rtl/core/adss_pkg.sv
// ----------------------------------------------------------------------------
// adss_pkg
// shared widths, codes and constants of the adc sample scaler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adss_pkg;

   localparam int PT_W      = 16;  // one breakpoint or scaled point
   localparam int NPTS      = 4;   // points packed in one csr
   localparam int CSR_W     = PT_W * NPTS;
   localparam int VALUE_W   = 32;  // q24.8 result
   localparam int GAIN_W    = 32;  // q16.16 gain
   localparam int YQ_W      = PT_W + 4;  // q12.4 point moved to q12.8, the fraction of q24.8
   localparam int QUO_W     = 20;  // interpolation quotient bits
   localparam int NUM_W     = 2 * PT_W;
   localparam int DIV_PER_STG = 4;
   localparam int DIV_STAGES  = QUO_W / DIV_PER_STG;

   typedef enum logic [1:0] {
      MODE_RAW     = 2'd0,
      MODE_LINEAR  = 2'd1,
      MODE_MAP     = 2'd2,
      MODE_INVALID = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_MODE    = 2'd0,
      CSR_GAIN    = 2'd1,
      CSR_RAW_PTS = 2'd2,
      CSR_SCL_PTS = 2'd3
   } csr_index_type;

   localparam logic signed [VALUE_W-1:0] NEG_ONE_Q8  = -32'sd256;
   localparam logic signed [GAIN_W-1:0]  GAIN_RESET  = 32'sd65536;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX   = 32'sh7fff_ffff;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN   = 32'sh8000_0000;

endpackage

// File: rtl/core/adss_req_if.sv
// ----------------------------------------------------------------------------
// adss_req_if
// sample channel: one converter code per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface adss_req_if #(
   parameter int ADC_BITS = 12
);
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] adc_code;

   modport source (output valid, output adc_code, input ready);
   modport sink   (input valid, input adc_code, output ready);
endinterface

// File: rtl/core/adss_rsp_if.sv
// ----------------------------------------------------------------------------
// adss_rsp_if
// result channel: one scaled value per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface adss_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [adss_pkg::VALUE_W-1:0]    scaled_value;
   logic                                   mode_error;

   modport source (output valid, output scaled_value, output mode_error, input ready);
   modport sink   (input valid, input scaled_value, input mode_error, output ready);
endinterface

// File: rtl/core/adc_sample_scaler.sv
// ----------------------------------------------------------------------------
// adc_sample_scaler: converter code to signed q24.8 (raw, gain or breakpoint map; invalid mode gives minus one)
// one sample per cycle sustained while the result side holds ready high
// depth is set by the 20-bit interpolation divider, 4 restoring steps per stage
// reset is synchronous: valid bits clear, csrs return to their reset values
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adc_sample_scaler #(
   parameter int BINS     = 4,
   parameter int ADC_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   adss_req_if.sink                      req_if,
   adss_rsp_if.source                    rsp_if,
   input  logic                          csr_wr_en,
   input  adss_pkg::csr_index_type       csr_index,
   input  logic [adss_pkg::CSR_W-1:0]    csr_wdata
);

   localparam int PT_W    = adss_pkg::PT_W;
   localparam int VALUE_W = adss_pkg::VALUE_W;
   localparam int GAIN_W  = adss_pkg::GAIN_W;
   localparam int YQ_W    = adss_pkg::YQ_W;
   localparam int QUO_W   = adss_pkg::QUO_W;
   localparam int NUM_W   = adss_pkg::NUM_W;
   localparam int BIN_W   = $clog2(BINS);
   localparam int PROD_W  = ADC_BITS + 1 + GAIN_W;

   // stage map: search, multiply, gain finish + divider load, divider, combine
   localparam int ST_A   = 0;
   localparam int ST_B   = 1;
   localparam int ST_C   = 2;
   localparam int ST_D0  = 3;
   localparam int NSTG   = ST_D0 + adss_pkg::DIV_STAGES + 1;
   localparam int ST_O   = NSTG - 1;

   // payload that travels down the pipe; fields are filled as stages need them
   typedef struct packed {
      logic                        interp;   // result comes from the divider
      logic                        linear;   // result comes from the gain product
      logic                        err;
      logic signed [VALUE_W-1:0]   value;
      logic [ADC_BITS-1:0]         code;
      logic signed [GAIN_W-1:0]    gain;
      logic signed [PROD_W-1:0]    prod;
      logic [PT_W-1:0]             dx;
      logic [PT_W-1:0]             dy_mag;
      logic                        dy_neg;
      logic [PT_W-1:0]             divisor;
      logic signed [YQ_W-1:0]      y1;
      logic [NUM_W-1:0]            num;
      logic [PT_W-1:0]             rem;
      logic [QUO_W-1:0]            sh;       // dividend bits out, quotient bits in
   } stage_type;

   // ---------------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------------
   adss_pkg::mode_type          mode_ff, mode_in;
   logic signed [GAIN_W-1:0]    gain_ff, gain_in;
   logic [adss_pkg::CSR_W-1:0]  raw_pts_ff, raw_pts_in;
   logic [adss_pkg::CSR_W-1:0]  scl_pts_ff, scl_pts_in;

   always_comb begin
      mode_in    = mode_ff;
      gain_in    = gain_ff;
      raw_pts_in = raw_pts_ff;
      scl_pts_in = scl_pts_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            adss_pkg::CSR_MODE:    mode_in    = adss_pkg::mode_type'(csr_wdata[1:0]);
            adss_pkg::CSR_GAIN:    gain_in    = csr_wdata[GAIN_W-1:0];
            adss_pkg::CSR_RAW_PTS: raw_pts_in = csr_wdata;
            adss_pkg::CSR_SCL_PTS: scl_pts_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= adss_pkg::MODE_RAW;
         gain_ff    <= adss_pkg::GAIN_RESET;
         raw_pts_ff <= '0;
         scl_pts_ff <= '0;
      end else begin
         mode_ff    <= mode_in;
         gain_ff    <= gain_in;
         raw_pts_ff <= raw_pts_in;
         scl_pts_ff <= scl_pts_in;
      end
   end

   // ---------------------------------------------------------------------------
   // one restoring division step; remainder stays below the divisor
   // ---------------------------------------------------------------------------
   function automatic logic [PT_W+QUO_W-1:0] div_step(
      input logic [PT_W-1:0]  rem,
      input logic [QUO_W-1:0] sh,
      input logic [PT_W-1:0]  d
   );
      logic [PT_W:0] t;
      logic [PT_W:0] diff;
      t    = {rem, sh[QUO_W-1]};
      diff = t - {1'b0, d};
      if (t >= {1'b0, d}) begin
         return {diff[PT_W-1:0], sh[QUO_W-2:0], 1'b1};
      end else begin
         return {t[PT_W-1:0], sh[QUO_W-2:0], 1'b0};
      end
   endfunction

   // ---------------------------------------------------------------------------
   // pipeline registers and flow control
   // ---------------------------------------------------------------------------
   stage_type         pipe_ff [NSTG];
   stage_type         pipe_in [NSTG];
   logic [NSTG-1:0]   vld_ff, vld_in;
   logic [NSTG-1:0]   take;      // stage may load this cycle

   // a stage loads when empty or when its content moves on; bubbles collapse
   always_comb begin
      take[ST_O] = !vld_ff[ST_O] || rsp_if.ready;
      for (int k = ST_O - 1; k >= 0; k--) begin
         take[k] = !vld_ff[k] || take[k+1];
      end
   end

   always_comb begin
      vld_in[ST_A] = take[ST_A] ? req_if.valid : vld_ff[ST_A];
      for (int k = 1; k < NSTG; k++) begin
         vld_in[k] = take[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign req_if.ready = take[ST_A];

   // ---------------------------------------------------------------------------
   // stage a: breakpoint search, operand selection, direct results
   // ---------------------------------------------------------------------------
   logic [BINS-1:0]  ge;      // breakpoint at or below the code
   logic [BIN_W-1:0] bin;
   logic [PT_W-1:0]  code16, x1, x2, s1, s2, s_first, s_last;
   logic [PT_W:0]    dy;

   always_comb begin
      pipe_in[ST_A] = '0;
      ge      = '0;
      bin     = '0;
      x1      = '0;
      x2      = '0;
      s1      = '0;
      s2      = '0;
      code16  = PT_W'(req_if.adc_code);
      s_first = scl_pts_ff[0 +: PT_W];
      s_last  = scl_pts_ff[(BINS-1)*PT_W +: PT_W];

      for (int i = 0; i < BINS; i++) begin
         ge[i] = (raw_pts_ff[i*PT_W +: PT_W] <= code16);
      end
      // highest-index breakpoint not above the code wins
      for (int i = 0; i < BINS; i++) begin
         if (ge[i]) begin
            bin = BIN_W'(i);
         end
      end
      for (int i = 0; i < BINS; i++) begin
         if (BIN_W'(i) == bin) begin
            x1 = raw_pts_ff[i*PT_W +: PT_W];
            s1 = scl_pts_ff[i*PT_W +: PT_W];
         end
         if (i == int'(bin) + 1) begin
            x2 = raw_pts_ff[i*PT_W +: PT_W];
            s2 = scl_pts_ff[i*PT_W +: PT_W];
         end
      end

      // inside a segment x1 <= code < x2, so dx < divisor and divisor > 0
      dy = {s2[PT_W-1], s2} - {s1[PT_W-1], s1};
      pipe_in[ST_A].code    = req_if.adc_code;
      pipe_in[ST_A].gain    = gain_ff;
      pipe_in[ST_A].dx      = code16 - x1;
      pipe_in[ST_A].divisor = x2 - x1;
      pipe_in[ST_A].dy_neg  = dy[PT_W];
      pipe_in[ST_A].dy_mag  = dy[PT_W] ? PT_W'(-dy) : dy[PT_W-1:0];
      pipe_in[ST_A].y1      = $signed({s1, 4'h0});

      unique case (mode_ff)
         adss_pkg::MODE_RAW: begin
            pipe_in[ST_A].value = VALUE_W'({req_if.adc_code, 8'h00});
         end
         adss_pkg::MODE_LINEAR: begin
            pipe_in[ST_A].linear = 1'b1;
         end
         adss_pkg::MODE_MAP: begin
            if (ge == '0) begin
               // below the first breakpoint
               pipe_in[ST_A].value = VALUE_W'($signed({s_first, 4'h0}));
            end else if (bin == BIN_W'(BINS - 1)) begin
               // at or past the last breakpoint
               pipe_in[ST_A].value = VALUE_W'($signed({s_last, 4'h0}));
            end else begin
               pipe_in[ST_A].interp = 1'b1;
            end
         end
         adss_pkg::MODE_INVALID: begin
            pipe_in[ST_A].err   = 1'b1;
            pipe_in[ST_A].value = adss_pkg::NEG_ONE_Q8;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // stage b: gain product and interpolation numerator
   // ---------------------------------------------------------------------------
   always_comb begin
      pipe_in[ST_B]      = pipe_ff[ST_A];
      pipe_in[ST_B].prod = PROD_W'($signed({1'b0, pipe_ff[ST_A].code}) * pipe_ff[ST_A].gain);
      pipe_in[ST_B].num  = NUM_W'(pipe_ff[ST_A].dx * pipe_ff[ST_A].dy_mag);
   end

   // ---------------------------------------------------------------------------
   // stage c: q16.16 product to q24.8 with saturation, divider load
   // ---------------------------------------------------------------------------
   logic signed [PROD_W-1:0] prod_b, prod_q;
   logic [PROD_W-VALUE_W:0]  prod_hi;

   always_comb begin
      pipe_in[ST_C] = pipe_ff[ST_B];
      // bias negative products so the shift truncates toward zero
      prod_b  = pipe_ff[ST_B].prod
              + $signed(PROD_W'({8{pipe_ff[ST_B].prod[PROD_W-1]}}));
      prod_q  = prod_b >>> 8;
      prod_hi = prod_q[PROD_W-1:VALUE_W-1];
      if (pipe_ff[ST_B].linear) begin
         if (prod_hi == '0 || prod_hi == '1) begin
            pipe_in[ST_C].value = prod_q[VALUE_W-1:0];
         end else begin
            pipe_in[ST_C].value = prod_q[PROD_W-1] ? adss_pkg::VALUE_MIN
                                                   : adss_pkg::VALUE_MAX;
         end
      end
      // dividend is num * 16; its top bits already sit below the divisor
      pipe_in[ST_C].rem = pipe_ff[ST_B].num[NUM_W-1 -: PT_W];
      pipe_in[ST_C].sh  = {pipe_ff[ST_B].num[NUM_W-PT_W-1:0], 4'h0};
   end

   // ---------------------------------------------------------------------------
   // divider stages
   // ---------------------------------------------------------------------------
   for (genvar k = ST_D0; k < ST_O; k++) begin : g_div
      always_comb begin
         pipe_in[k] = pipe_ff[k-1];
         for (int s = 0; s < adss_pkg::DIV_PER_STG; s++) begin
            {pipe_in[k].rem, pipe_in[k].sh} =
               div_step(pipe_in[k].rem, pipe_in[k].sh, pipe_in[k].divisor);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // output stage: signed quotient plus lower scaled point
   // ---------------------------------------------------------------------------
   logic signed [QUO_W:0] quo_s;

   always_comb begin
      pipe_in[ST_O] = pipe_ff[ST_O-1];
      quo_s = $signed({1'b0, pipe_ff[ST_O-1].sh});
      if (pipe_ff[ST_O-1].dy_neg) begin
         quo_s = -quo_s;
      end
      if (pipe_ff[ST_O-1].interp) begin
         pipe_in[ST_O].value = VALUE_W'(pipe_ff[ST_O-1].y1) + VALUE_W'(quo_s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      for (int k = 0; k < NSTG; k++) begin
         if (take[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign rsp_if.valid        = vld_ff[ST_O];
   assign rsp_if.scaled_value = pipe_ff[ST_O].value;
   assign rsp_if.mode_error   = pipe_ff[ST_O].err;

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
   `ADSS_ASSERT(a_seg_order, clock, reset, vld_ff[ST_A] && pipe_ff[ST_A].interp |-> pipe_ff[ST_A].dx < pipe_ff[ST_A].divisor, "segment offset not below segment width")
   `ADSS_ASSERT(a_div_load, clock, reset, vld_ff[ST_C] && pipe_ff[ST_C].interp |-> pipe_ff[ST_C].rem < pipe_ff[ST_C].divisor, "divider loaded with quotient overflow")
   `ADSS_ASSERT(a_stall_hold, clock, reset, vld_ff[ST_C] && !take[ST_C] |=> vld_ff[ST_C] && $stable(pipe_ff[ST_C]), "stalled stage lost its item")
   `ADSS_ASSERT_NEVER(a_err_value, clock, reset, vld_ff[ST_O] && pipe_ff[ST_O].err && (pipe_ff[ST_O].value != adss_pkg::NEG_ONE_Q8 || pipe_ff[ST_O].interp || pipe_ff[ST_O].linear), "error result without minus one")

endmodule

// File: tb/sv/adss_scaler_checker.sv
// ----------------------------------------------------------------------------
// adss_scaler_checker
// watches the sample, result and csr ports of the adc sample scaler, keeps
// its own copy of the csrs, predicts each scaled value and compares it in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adss_scaler_checker import adss_pkg::*; #(
   parameter int BINS = 4
) (
   input  logic               clock,
   input  logic               reset,
   adss_req_if                req_mon,
   adss_rsp_if                rsp_mon,
   input  logic               csr_wr_en,
   input  csr_index_type      csr_index,
   input  logic [CSR_W-1:0]   csr_wdata,
   output int                 fail_count,
   output int                 outstanding
);

   typedef struct {
      logic [11:0]                code;
      logic signed [VALUE_W-1:0]  value;
      logic                       error;
   } scaled_sample_type;

   scaled_sample_type           pending_samples[$];
   scaled_sample_type           oldest;
   int                          mismatches = 0;

   mode_type                    cfg_mode;
   logic signed [GAIN_W-1:0]    cfg_gain;
   logic [CSR_W-1:0]            cfg_raw_pts;
   logic [CSR_W-1:0]            cfg_scl_pts;

   function automatic longint clamp_q8(input longint v);
      if (v > longint'(VALUE_MAX)) return longint'(VALUE_MAX);
      if (v < longint'(VALUE_MIN)) return longint'(VALUE_MIN);
      return v;
   endfunction

   function automatic longint breakpoint_at(input int i);
      return longint'(cfg_raw_pts[PT_W*(i % NPTS) +: PT_W]);
   endfunction

   // q12.4 point widened to q24.8
   function automatic longint scaled_point_at(input int i);
      return longint'($signed(cfg_scl_pts[PT_W*(i % NPTS) +: PT_W])) * 16;
   endfunction

   function automatic longint interpolate(input longint c);
      int     bin;
      longint x1, x2, y1, y2;
      bin = BINS - 1;
      while (bin > 0 && c < breakpoint_at(bin))
         bin--;
      if (bin == 0 && c < breakpoint_at(0))
         return scaled_point_at(0);
      if (bin >= BINS - 1)
         return scaled_point_at(BINS - 1);
      x1 = breakpoint_at(bin);
      x2 = breakpoint_at(bin + 1);
      y1 = scaled_point_at(bin);
      y2 = scaled_point_at(bin + 1);
      if (x2 == x1)
         return y1;
      // longint division truncates toward zero
      return clamp_q8(y1 + ((c - x1) * (y2 - y1)) / (x2 - x1));
   endfunction

   function automatic scaled_sample_type scale_code(input logic [11:0] code);
      scaled_sample_type r;
      longint            c, y;
      c = longint'(code);
      r.code  = code;
      r.error = 1'b0;
      case (cfg_mode)
         MODE_RAW:    y = c * 256;
         MODE_LINEAR: y = clamp_q8((longint'(cfg_gain) * c) / 256);
         MODE_MAP:    y = interpolate(c);
         default: begin
            y = longint'(NEG_ONE_Q8);
            r.error = 1'b1;
         end
      endcase
      r.value = y[VALUE_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_mode    = MODE_RAW;
         cfg_gain    = GAIN_RESET;
         cfg_raw_pts = '0;
         cfg_scl_pts = '0;
         pending_samples.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_samples.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: value %0d error %0b",
                           rsp_mon.scaled_value, rsp_mon.mode_error);
            end else begin
               oldest = pending_samples.pop_front();
               if (rsp_mon.scaled_value !== oldest.value ||
                   rsp_mon.mode_error !== oldest.error) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch for code %0d: expected value %0d error %0b,",
                               " got value %0d error %0b"},
                              oldest.code, oldest.value, oldest.error,
                              rsp_mon.scaled_value, rsp_mon.mode_error);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_samples.push_back(scale_code(req_mon.adc_code));
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MODE:    cfg_mode    = mode_type'(csr_wdata[1:0]);
               CSR_GAIN:    cfg_gain    = csr_wdata[GAIN_W-1:0];
               CSR_RAW_PTS: cfg_raw_pts = csr_wdata;
               CSR_SCL_PTS: cfg_scl_pts = csr_wdata;
               default: ;
            endcase
         end
      end
      fail_count  <= mismatches;
      outstanding <= pending_samples.size();
   end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// adc sample scaler testbench
// directed and random samples across raw, gain, breakpoint map and invalid
// modes, with bursty sample traffic and a stalling result side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import adss_pkg::*;

   localparam int ADC_BITS      = 12;
   localparam int BINS          = 4;
   localparam int RANDOM_ITEMS  = 1850;
   localparam int SETTLE_CYCLES = 20;         // idle time before the final check
   localparam int RUN_LIMIT_NS  = 2_000_000;  // hard limit, far beyond a slow run

   // receiver stall patterns, one picked per phase
   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PERIODIC,
      READY_BURSTY
   } ready_style_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   csr_index_type     csr_index;
   logic [CSR_W-1:0]  csr_wdata;
   int                fail_count;
   int                outstanding;

   // stimulus state
   int                items_sent = 0;
   int                burst_left = 0;
   bit                steady_sender = 1'b1;
   ready_style_type   ready_style = READY_ALWAYS;
   int                stall_period = 3;
   int                stall_tick = 0;
   int                stall_hold = 0;
   logic [CSR_W-1:0]  cur_raw_pts = '0;
   int                random_target;
   int                phase_len;

   adss_req_if #(.ADC_BITS(ADC_BITS)) req_ch ();
   adss_rsp_if                         rsp_ch ();

   adc_sample_scaler #(
      .BINS     (BINS),
      .ADC_BITS (ADC_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   adss_scaler_checker #(.BINS(BINS)) scaler_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #2 clock = ~clock;

   // hard stop in case the pipeline hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("testbench failed");
      $finish;
   end

   // result side: ready follows the pattern chosen for the current phase
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         stall_tick++;
         case (ready_style)
            READY_ALWAYS:   rsp_ch.ready <= 1'b1;
            READY_RANDOM:   rsp_ch.ready <= ($urandom_range(0, 2) != 0);
            READY_PERIODIC: rsp_ch.ready <= (stall_tick % stall_period) != 0;
            default: begin
               // mostly ready, now and then a long stall
               if (stall_hold > 0) begin
                  stall_hold--;
                  rsp_ch.ready <= 1'b0;
               end else if ($urandom_range(0, 19) == 0) begin
                  stall_hold = $urandom_range(4, 12);
                  rsp_ch.ready <= 1'b0;
               end else begin
                  rsp_ch.ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // one csr write, enable left high so back-to-back writes need no toggle
   task automatic write_csr(input csr_index_type idx, input logic [CSR_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_setup(input logic [CSR_W-1:0] mode_word,
                             input logic [CSR_W-1:0] gain_word,
                             input logic [CSR_W-1:0] raw_word,
                             input logic [CSR_W-1:0] scl_word);
      write_csr(CSR_MODE, mode_word);
      write_csr(CSR_GAIN, gain_word);
      write_csr(CSR_RAW_PTS, raw_word);
      write_csr(CSR_SCL_PTS, scl_word);
      csr_wr_en <= 1'b0;
      cur_raw_pts = raw_word;
   endtask

   // one sample transfer; the sender idles between bursts unless steady
   task automatic send_code(input logic [ADC_BITS-1:0] code);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (!steady_sender) begin
            gap = $urandom_range(1, 6);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_ch.valid    <= 1'b1;
      req_ch.adc_code <= code;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      burst_left--;
      items_sent++;
   endtask

   // drain: every sample in flight has produced its result
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // traffic shape for the next phase
   task automatic pick_idling();
      steady_sender = ($urandom_range(0, 3) == 0);
      burst_left    = 0;
      ready_style   = ready_style_type'($urandom_range(0, 3));
      stall_period  = $urandom_range(2, 7);
   endtask

   task automatic random_setup();
      logic [CSR_W-1:0] mode_word, gain_word, raw_word, scl_word;
      logic [19:0]      small_gain;
      int               pts[$];
      int               pick, k;
      mode_word = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 15)      mode_word[1:0] = MODE_RAW;
      else if (pick < 45) mode_word[1:0] = MODE_LINEAR;
      else if (pick < 85) mode_word[1:0] = MODE_MAP;
      else                mode_word[1:0] = MODE_INVALID;

      gain_word = {$urandom, $urandom};
      small_gain = 20'($urandom);
      case ($urandom_range(0, 9))
         0: gain_word[31:0] = 32'h7fff_ffff;
         1: gain_word[31:0] = 32'h8000_0000;
         2: gain_word[31:0] = 32'h0000_0000;
         3, 4, 5: gain_word[31:0] = {{12{small_gain[19]}}, small_gain};  // within +-8.0
         default: ;
      endcase

      // breakpoints: mostly ascending inside the code range
      pick = $urandom_range(0, 9);
      for (int i = 0; i < NPTS; i++)
         pts.push_back(pick == 1 ? int'($urandom_range(0, 65535))
                                 : int'($urandom_range(0, 4095)));
      pts.sort();
      if (pick > 1 && $urandom_range(0, 3) == 0) begin
         k = $urandom_range(0, NPTS - 2);
         pts[k + 1] = pts[k];
      end
      for (int i = 0; i < NPTS; i++)
         raw_word[PT_W*i +: PT_W] = pts[i][PT_W-1:0];
      if (pick == 0)
         raw_word = {$urandom, $urandom};  // arbitrary order

      scl_word = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0)
         for (int i = 0; i < NPTS; i++)
            if ($urandom_range(0, 1) == 0)
               scl_word[PT_W*i +: PT_W] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;

      load_setup(mode_word, gain_word, raw_word, scl_word);
   endtask

   // codes: extremes, neighborhoods of the breakpoints, or anything
   function automatic logic [ADC_BITS-1:0] pick_code();
      int k, idx, near;
      k = $urandom_range(0, 99);
      if (k < 5)  return '0;
      if (k < 10) return '1;
      if (k < 40) begin
         idx  = $urandom_range(0, NPTS - 1);
         near = int'(cur_raw_pts[PT_W*idx +: PT_W]) + int'($urandom_range(0, 4)) - 2;
         if (near < 0) near = 0;
         if (near > 4095) near = 4095;
         return near[ADC_BITS-1:0];
      end
      return ADC_BITS'($urandom);
   endfunction

   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.adc_code <= '0;
      csr_wr_en       <= 1'b0;
      csr_index       <= CSR_MODE;
      csr_wdata       <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // csrs at their reset values: raw pass-through
      send_code(12'd0);
      send_code(12'hfff);
      wait_drained();

      // linear with the reset gain of 1.0
      write_csr(CSR_MODE, CSR_W'(MODE_LINEAR));
      csr_wr_en <= 1'b0;
      send_code(12'hfff);
      wait_drained();

      // raw, alternating bit patterns
      load_setup(CSR_W'(MODE_RAW), 64'h0, 64'h0, 64'h0);
      send_code(12'haaa);
      send_code(12'h555);
      wait_drained();

      // largest gain saturates high, smallest saturates low
      load_setup(CSR_W'(MODE_LINEAR), 64'h7fff_ffff, 64'h0, 64'h0);
      send_code(12'hfff);
      send_code(12'd1);
      wait_drained();
      load_setup(CSR_W'(MODE_LINEAR), 64'h8000_0000, 64'h0, 64'h0);
      send_code(12'hfff);
      send_code(12'd0);
      wait_drained();
      // gain of -1.0
      load_setup(CSR_W'(MODE_LINEAR), 64'hffff_0000, 64'h0, 64'h0);
      send_code(12'd3);
      wait_drained();

      // ascending map: below first, on first, inside, on last, above last
      load_setup(CSR_W'(MODE_MAP), 64'h0,
                 {16'd3000, 16'd2000, 16'd1000, 16'd100},
                 {16'h8000, 16'h7fff, 16'h0320, 16'hff9c});
      send_code(12'd50);
      send_code(12'd100);
      send_code(12'd550);
      send_code(12'd1700);
      send_code(12'd3000);
      send_code(12'd4095);
      wait_drained();

      // breakpoints out of order
      load_setup(CSR_W'(MODE_MAP), 64'h0,
                 {16'd4000, 16'd2000, 16'd100, 16'd3000},
                 {16'h1234, 16'hedcb, 16'h0010, 16'hfff0});
      send_code(12'd50);
      send_code(12'd150);
      send_code(12'd3500);
      wait_drained();

      // equal neighboring breakpoints
      load_setup(CSR_W'(MODE_MAP), 64'h0,
                 {16'd3000, 16'd500, 16'd500, 16'd100},
                 {16'h0400, 16'hfc00, 16'h0200, 16'h0100});
      send_code(12'd500);
      send_code(12'd499);
      wait_drained();

      // invalid mode, upper csr bits all set
      load_setup(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
      send_code(12'd7);
      wait_drained();

      // ---- random part ----
      random_target = items_sent + RANDOM_ITEMS;
      while (items_sent < random_target) begin
         random_setup();
         pick_idling();
         phase_len = $urandom_range(10, 120);
         repeat (phase_len) send_code(pick_code());
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
